### src/chmc_pkg.sv
// ----------------------------------------------------------------------------
// chmc_pkg: shared types and constants of the compass heading block
// Request record, back-end state codes, opcodes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package chmc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DEG_W    = 9;
    localparam int TBL_LEN  = 24;

    localparam logic OP_CAL = 1'b0;
    localparam logic OP_HDG = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] EXT_MAX_RST = -16'sd10000;
    localparam logic signed [SAMPLE_W-1:0] EXT_MIN_RST = 16'sd10000;

    localparam logic signed [25:0] PI_UNITS = 26'sd11796828;
    localparam logic [DEG_W-1:0]   DEG_FULL = 9'd360;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] x_max;
        logic signed [SAMPLE_W-1:0] x_min;
        logic signed [SAMPLE_W-1:0] y_max;
        logic signed [SAMPLE_W-1:0] y_min;
    } t_hdg_req;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_MUL,
        BK_ABS,
        BK_NORM,
        BK_ROT,
        BK_ANG,
        BK_DONE
    } t_back_state;

    function automatic logic [21:0] atan_units(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949207;
            5'd1:    v = 22'd1741019;
            5'd2:    v = 22'd919906;
            5'd3:    v = 22'd466959;
            5'd4:    v = 22'd234386;
            5'd5:    v = 22'd117307;
            5'd6:    v = 22'd58668;
            5'd7:    v = 22'd29336;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1834;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

### src/chmc_fifo.sv
// ----------------------------------------------------------------------------
// chmc_fifo: short request queue
// Register-based FIFO between the front end and the heading engine.
// ----------------------------------------------------------------------------
module chmc_fifo #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### src/chmc_front.sv
// ----------------------------------------------------------------------------
// chmc_front: input stage and calibration extremes
// Accepts items, widens the stored extremes on calibration items and queues
// heading items together with a snapshot of the extremes.
// ----------------------------------------------------------------------------
module chmc_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [31:0]              i_s_tdata,   // mag_x[15:0], mag_y[31:16]
    input  logic                     i_s_tuser,   // opcode
    output logic                     o_q_valid,
    input  logic                     i_q_ready,
    output chmc_pkg::t_hdg_req       o_q_req
);

    localparam int SH = chmc_pkg::SAMPLE_W - SAMPLE_BITS;

    logic signed [chmc_pkg::SAMPLE_W-1:0] r_x_max, n_x_max;
    logic signed [chmc_pkg::SAMPLE_W-1:0] r_x_min, n_x_min;
    logic signed [chmc_pkg::SAMPLE_W-1:0] r_y_max, n_y_max;
    logic signed [chmc_pkg::SAMPLE_W-1:0] r_y_min, n_y_min;
    logic signed [chmc_pkg::SAMPLE_W-1:0] w_x_sh, w_y_sh;
    logic signed [chmc_pkg::SAMPLE_W-1:0] w_x, w_y;
    logic                                 w_accept;

    assign w_x_sh = $signed(i_s_tdata[15:0] << SH);
    assign w_y_sh = $signed(i_s_tdata[31:16] << SH);
    assign w_x    = w_x_sh >>> SH;
    assign w_y    = w_y_sh >>> SH;

    assign o_s_tready = i_q_ready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_q_valid  = w_accept && (i_s_tuser == chmc_pkg::OP_HDG);

    always_comb begin
        o_q_req.x     = w_x;
        o_q_req.y     = w_y;
        o_q_req.x_max = r_x_max;
        o_q_req.x_min = r_x_min;
        o_q_req.y_max = r_y_max;
        o_q_req.y_min = r_y_min;
    end

    always_comb begin
        n_x_max = r_x_max;
        n_x_min = r_x_min;
        n_y_max = r_y_max;
        n_y_min = r_y_min;
        if (w_accept && (i_s_tuser == chmc_pkg::OP_CAL)) begin
            if (w_x > r_x_max) n_x_max = w_x;
            if (w_x < r_x_min) n_x_min = w_x;
            if (w_y > r_y_max) n_y_max = w_y;
            if (w_y < r_y_min) n_y_min = w_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_max <= chmc_pkg::EXT_MAX_RST;
            r_x_min <= chmc_pkg::EXT_MIN_RST;
            r_y_max <= chmc_pkg::EXT_MAX_RST;
            r_y_min <= chmc_pkg::EXT_MIN_RST;
        end else begin
            r_x_max <= n_x_max;
            r_x_min <= n_x_min;
            r_y_max <= n_y_max;
            r_y_min <= n_y_min;
        end
    end

endmodule

### src/chmc_back.sv
// ----------------------------------------------------------------------------
// chmc_back: heading engine
// Centers and cross-scales the sample, normalizes it, runs an iterative
// CORDIC vectoring loop and converts the angle to whole degrees.
// ----------------------------------------------------------------------------
module chmc_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  chmc_pkg::t_hdg_req   i_q_req,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [15:0]          o_m_tdata,   // heading[8:0], zero fill
    output logic                 o_m_tuser    // uncalibrated
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam int MAG_W = 41;

    chmc_pkg::t_back_state r_state, n_state;
    chmc_pkg::t_hdg_req    r_req, n_req;

    logic signed [17:0] r_dx, n_dx, r_dy, n_dy;
    logic signed [16:0] r_rx, n_rx, r_ry, n_ry;
    logic signed [34:0] r_bx, n_bx, r_by, n_by;
    logic [MAG_W-1:0]   r_ax, n_ax, r_ay, n_ay;
    logic               r_xneg, n_xneg, r_yneg, n_yneg;
    logic signed [43:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [25:0] r_z, n_z;
    logic [CNT_W-1:0]   r_iter, n_iter;
    logic [chmc_pkg::DEG_W-1:0] r_res_deg, n_res_deg;
    logic               r_res_uncal, n_res_uncal;
    logic               r_out_valid, n_out_valid;
    logic [chmc_pkg::DEG_W-1:0] r_out_deg, n_out_deg;
    logic               r_out_uncal, n_out_uncal;

    logic signed [16:0] w_rx, w_ry, w_xsum, w_ysum, w_xoff, w_yoff;
    logic signed [17:0] w_dx, w_dy;
    logic signed [34:0] w_bx, w_by, w_bx_abs, w_by_abs;
    logic [MAG_W-1:32]  w_or;
    logic signed [43:0] w_tx, w_ty;
    logic signed [25:0] w_step, w_ang, w_ang_abs;
    logic [chmc_pkg::DEG_W-1:0] w_q, w_deg;

    assign w_rx   = 17'(r_req.x_max) - 17'(r_req.x_min);
    assign w_ry   = 17'(r_req.y_max) - 17'(r_req.y_min);
    assign w_xsum = 17'(r_req.x_max) + 17'(r_req.x_min);
    assign w_ysum = 17'(r_req.y_max) + 17'(r_req.y_min);
    assign w_xoff = (w_xsum + $signed({16'd0, w_xsum[16]})) >>> 1;
    assign w_yoff = (w_ysum + $signed({16'd0, w_ysum[16]})) >>> 1;
    assign w_dx   = 18'(r_req.x) - 18'(w_xoff);
    assign w_dy   = 18'(r_req.y) - 18'(w_yoff);

    assign w_bx     = r_dx * r_ry;
    assign w_by     = r_dy * r_rx;
    assign w_bx_abs = r_bx[34] ? -r_bx : r_bx;
    assign w_by_abs = r_by[34] ? -r_by : r_by;
    assign w_or     = r_ax[MAG_W-1:32] | r_ay[MAG_W-1:32];

    assign w_tx   = r_cx >>> r_iter;
    assign w_ty   = r_cy >>> r_iter;
    assign w_step = 26'(chmc_pkg::atan_units(5'(r_iter)));

    always_comb begin
        if (r_xneg) begin
            w_ang = r_yneg ? (r_z - chmc_pkg::PI_UNITS) : (chmc_pkg::PI_UNITS - r_z);
        end else begin
            w_ang = r_yneg ? -r_z : r_z;
        end
    end
    assign w_ang_abs = w_ang[25] ? -w_ang : w_ang;
    assign w_q       = w_ang_abs[24:16];
    assign w_deg     = (w_ang[25] && (w_q != '0)) ? (chmc_pkg::DEG_FULL - w_q) : w_q;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_rx        = r_rx;
        n_ry        = r_ry;
        n_bx        = r_bx;
        n_by        = r_by;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_xneg      = r_xneg;
        n_yneg      = r_yneg;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_z         = r_z;
        n_iter      = r_iter;
        n_res_deg   = r_res_deg;
        n_res_uncal = r_res_uncal;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_deg   = r_out_deg;
        n_out_uncal = r_out_uncal;
        o_q_ready   = 1'b0;
        case (r_state)
            chmc_pkg::BK_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    n_req   = i_q_req;
                    n_state = chmc_pkg::BK_PREP;
                end
            end
            chmc_pkg::BK_PREP: begin
                n_rx = w_rx;
                n_ry = w_ry;
                n_dx = w_dx;
                n_dy = w_dy;
                if (w_rx[16] || (w_rx == '0) || w_ry[16] || (w_ry == '0)) begin
                    n_res_deg   = '0;
                    n_res_uncal = 1'b1;
                    n_state     = chmc_pkg::BK_DONE;
                end else begin
                    n_state = chmc_pkg::BK_MUL;
                end
            end
            chmc_pkg::BK_MUL: begin
                n_bx    = w_bx;
                n_by    = w_by;
                n_state = chmc_pkg::BK_ABS;
            end
            chmc_pkg::BK_ABS: begin
                n_ax   = MAG_W'(unsigned'(w_bx_abs));
                n_ay   = MAG_W'(unsigned'(w_by_abs));
                n_xneg = r_bx[34];
                n_yneg = r_by[34];
                if ((r_bx == '0) && (r_by == '0)) begin
                    n_res_deg   = '0;
                    n_res_uncal = 1'b0;
                    n_state     = chmc_pkg::BK_DONE;
                end else begin
                    n_state = chmc_pkg::BK_NORM;
                end
            end
            chmc_pkg::BK_NORM: begin
                if (w_or[MAG_W-1:32] == '0) begin
                    n_ax = r_ax << 8;
                    n_ay = r_ay << 8;
                end else if (!w_or[MAG_W-1]) begin
                    n_ax = r_ax << 1;
                    n_ay = r_ay << 1;
                end else begin
                    n_cx    = 44'(r_ax);
                    n_cy    = 44'(r_ay);
                    n_z     = '0;
                    n_iter  = '0;
                    n_state = chmc_pkg::BK_ROT;
                end
            end
            chmc_pkg::BK_ROT: begin
                if (!r_cy[43]) begin
                    n_cx = r_cx + w_ty;
                    n_cy = r_cy - w_tx;
                    n_z  = r_z + w_step;
                end else begin
                    n_cx = r_cx - w_ty;
                    n_cy = r_cy + w_tx;
                    n_z  = r_z - w_step;
                end
                n_iter = r_iter + 1'b1;
                if (r_iter == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = chmc_pkg::BK_ANG;
                end
            end
            chmc_pkg::BK_ANG: begin
                n_res_deg   = w_deg;
                n_res_uncal = 1'b0;
                n_state     = chmc_pkg::BK_DONE;
            end
            chmc_pkg::BK_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_deg   = r_res_deg;
                    n_out_uncal = r_res_uncal;
                    n_state     = chmc_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = chmc_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chmc_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_rx        <= n_rx;
        r_ry        <= n_ry;
        r_bx        <= n_bx;
        r_by        <= n_by;
        r_ax        <= n_ax;
        r_ay        <= n_ay;
        r_xneg      <= n_xneg;
        r_yneg      <= n_yneg;
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_z         <= n_z;
        r_iter      <= n_iter;
        r_res_deg   <= n_res_deg;
        r_res_uncal <= n_res_uncal;
        r_out_deg   <= n_out_deg;
        r_out_uncal <= n_out_uncal;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = 16'(r_out_deg);
    assign o_m_tuser  = r_out_uncal;

    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_uncal) |-> (r_out_deg == '0))
        else $error("uncalibrated result with nonzero heading");

    a_deg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_deg < chmc_pkg::DEG_FULL))
        else $error("heading out of range");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == chmc_pkg::BK_DONE))
        else $error("result loaded outside the finish step");

    a_rot_after_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == chmc_pkg::BK_ROT) && (r_iter == '0))
        |-> ((r_cx[43:MAG_W-1] | r_cy[43:MAG_W-1]) == 4'd1))
        else $error("rotation started on an unnormalized vector");

endmodule

### src/compass_heading_with_minmax_calibration.sv
// ----------------------------------------------------------------------------
// compass_heading_with_minmax_calibration: magnetometer compass heading
// Min/max hard-iron calibration and CORDIC heading in whole degrees.
// ----------------------------------------------------------------------------
// Calibration items update the extremes in the front end and give no result.
// Heading items pass the queue, then the engine's centering, multiply, magnitude,
// normalizing shifter and one-step-per-cycle CORDIC; uncalibrated ranges and a
// zero vector end early. The engine takes no new item until its result is in the
// output register; a two-entry queue buffers more. Synchronous active-low reset
// restores extremes to -10000/+10000 and empties the queue and output register.
module compass_heading_with_minmax_calibration #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,    // mag_x[15:0], mag_y[31:16]
    input  logic        i_s_tuser,    // opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,    // heading[8:0], zero fill
    output logic        o_m_tuser     // uncalibrated
);

    localparam int REQ_W = $bits(chmc_pkg::t_hdg_req);

    logic               w_push_valid;
    logic               w_push_ready;
    chmc_pkg::t_hdg_req w_push_req;
    logic               w_pop_valid;
    logic               w_pop_ready;
    logic [REQ_W-1:0]   w_pop_bits;
    chmc_pkg::t_hdg_req w_pop_req;

    assign w_pop_req = chmc_pkg::t_hdg_req'(w_pop_bits);

    chmc_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (w_push_valid),
        .i_q_ready  (w_push_ready),
        .o_q_req    (w_push_req)
    );

    chmc_fifo #(
        .WIDTH(REQ_W),
        .DEPTH(2)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_push_valid),
        .o_wr_ready (w_push_ready),
        .i_wr_data  (REQ_W'(w_push_req)),
        .o_rd_valid (w_pop_valid),
        .i_rd_ready (w_pop_ready),
        .o_rd_data  (w_pop_bits)
    );

    chmc_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_pop_valid),
        .o_q_ready  (w_pop_ready),
        .i_q_req    (w_pop_req),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

### bench/chmc_heading_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chmc_heading_checker: scoreboard for the compass heading block
// Watches the sample and heading streams and tracks the calibration extremes.
// Each heading item is predicted with an independent CORDIC and compared in
// order against the results that the block hands out.
// ----------------------------------------------------------------------------
module chmc_heading_checker #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,    // mag_x[15:0], mag_y[31:16]
    input  logic        i_s_tuser,    // opcode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,    // heading[8:0], zero fill
    input  logic        i_m_tuser,    // uncalibrated
    output int          o_errors,
    output int          o_outstanding
);

    typedef struct packed {
        logic [chmc_pkg::DEG_W-1:0] deg;
        logic                       uncal;
    } t_heading;

    localparam longint ANGLE_PI   = 64'sd11796828;
    localparam longint NORM_FLOOR = 64'sd1099511627776;
    localparam int     ATAN_STEPS = 24;

    logic signed [chmc_pkg::SAMPLE_W-1:0] x_hi, x_lo, y_hi, y_lo;
    t_heading                             headings_due[$];
    int                                   mismatches;

    function automatic longint atan_step(input int idx);
        case (idx)
            0:       return 2949207;
            1:       return 1741019;
            2:       return 919906;
            3:       return 466959;
            4:       return 234386;
            5:       return 117307;
            6:       return 58668;
            7:       return 29336;
            8:       return 14668;
            9:       return 7334;
            10:      return 3667;
            11:      return 1834;
            12:      return 917;
            13:      return 458;
            14:      return 229;
            15:      return 115;
            16:      return 57;
            17:      return 29;
            18:      return 14;
            19:      return 7;
            20:      return 4;
            21:      return 2;
            22:      return 1;
            default: return 0;
        endcase
    endfunction

    // keep the low SAMPLE_BITS bits, sign-extended
    function automatic logic signed [chmc_pkg::SAMPLE_W-1:0] narrow_sample(
        input logic [chmc_pkg::SAMPLE_W-1:0] raw);
        logic signed [chmc_pkg::SAMPLE_W-1:0] t;
        t = raw << (chmc_pkg::SAMPLE_W - SAMPLE_BITS);
        return t >>> (chmc_pkg::SAMPLE_W - SAMPLE_BITS);
    endfunction

    function automatic logic [chmc_pkg::DEG_W-1:0] vector_degrees(input longint vx,
                                                                 input longint vy);
        longint mag_x, mag_y, cx, cy, tx, ty, z, a, deg;
        if (vx == 0 && vy == 0) begin
            return '0;
        end
        mag_x = (vx < 0) ? -vx : vx;
        mag_y = (vy < 0) ? -vy : vy;
        while (((mag_x > mag_y) ? mag_x : mag_y) < NORM_FLOOR) begin
            mag_x = mag_x <<< 1;
            mag_y = mag_y <<< 1;
        end
        cx = mag_x;
        cy = mag_y;
        z  = 0;
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_STEPS; i++) begin
            tx = cx >>> i;
            ty = cy >>> i;
            if (cy >= 0) begin
                cx = cx + ty;
                cy = cy - tx;
                z  = z + atan_step(i);
            end else begin
                cx = cx - ty;
                cy = cy + tx;
                z  = z - atan_step(i);
            end
        end
        if (vx >= 0) begin
            a = (vy >= 0) ? z : -z;
        end else begin
            a = (vy >= 0) ? (ANGLE_PI - z) : (z - ANGLE_PI);
        end
        deg = (a >= 0) ? (a >>> 16) : -((-a) >>> 16);
        if (deg < 0) begin
            deg = deg + 360;
        end
        return chmc_pkg::DEG_W'(deg);
    endfunction

    function automatic t_heading predict_heading(
        input logic signed [chmc_pkg::SAMPLE_W-1:0] x,
        input logic signed [chmc_pkg::SAMPLE_W-1:0] y);
        int       span_x, span_y, mid_x, mid_y;
        t_heading r;
        span_x = int'(x_hi) - int'(x_lo);
        span_y = int'(y_hi) - int'(y_lo);
        if (span_x <= 0 || span_y <= 0) begin
            r.deg   = '0;
            r.uncal = 1'b1;
            return r;
        end
        mid_x   = (int'(x_hi) + int'(x_lo)) / 2;
        mid_y   = (int'(y_hi) + int'(y_lo)) / 2;
        r.deg   = vector_degrees(longint'(int'(x) - mid_x) * longint'(span_y),
                                 longint'(int'(y) - mid_y) * longint'(span_x));
        r.uncal = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_heading                             want;
        logic signed [chmc_pkg::SAMPLE_W-1:0] sx, sy;
        if (!i_rst_n) begin
            x_hi = chmc_pkg::EXT_MAX_RST;
            x_lo = chmc_pkg::EXT_MIN_RST;
            y_hi = chmc_pkg::EXT_MAX_RST;
            y_lo = chmc_pkg::EXT_MIN_RST;
            headings_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (headings_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected heading item: deg %0d uncal %0b",
                                 $time, i_m_tdata, i_m_tuser);
                    end
                end else begin
                    want = headings_due.pop_front();
                    if (i_m_tdata != 16'(want.deg) || i_m_tuser != want.uncal) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: heading mismatch: exp deg %0d uncal %0b, ",
                                      "got deg %0d uncal %0b"},
                                     $time, want.deg, want.uncal, i_m_tdata, i_m_tuser);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                sx = narrow_sample(i_s_tdata[15:0]);
                sy = narrow_sample(i_s_tdata[31:16]);
                if (i_s_tuser == chmc_pkg::OP_CAL) begin
                    if (sx > x_hi) x_hi = sx;
                    if (sx < x_lo) x_lo = sx;
                    if (sy > y_hi) y_hi = sy;
                    if (sy < y_lo) y_lo = sy;
                end else begin
                    headings_due.push_back(predict_heading(sx, sy));
                end
            end
        end
        o_outstanding <= headings_due.size();
        o_errors      <= mismatches;
    end

endmodule

### bench/tb_compass_heading_with_minmax_calibration.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_compass_heading_with_minmax_calibration: compass heading block testbench
// Directed calibration and heading items cover uncalibrated ranges, truncated
// midpoints, the zero vector, the negative x axis and the quadrant edges; a
// random phase then widens the extremes step by step, mostly under random backpressure.
// ----------------------------------------------------------------------------
module tb_compass_heading_with_minmax_calibration;

    localparam int CORDIC_STEPS = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int RANDOM_ITEMS = 830;
    localparam int DRAIN_CYCLES = CORDIC_STEPS + 24;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // mag_x[15:0], mag_y[31:16]
    logic        s_tuser  = 1'b0;  // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // heading[8:0], zero fill
    logic        m_tuser;          // uncalibrated
    logic        steady   = 1'b0;
    int          errors;
    int          outstanding;
    int          cycles   = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    compass_heading_with_minmax_calibration #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    chmc_heading_checker #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 37);
    end

    task automatic send_item(input logic op, input logic [15:0] x, input logic [15:0] y);
        while (!steady && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {y, x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // uniform in [-w, w]
    function automatic logic [15:0] around(input int w);
        return 16'(int'($urandom_range(2 * w)) - w);
    endfunction

    function automatic logic [15:0] rail_sample();
        case ($urandom_range(3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    initial begin
        int          w, w2, sel;
        logic        op;
        logic [15:0] vx, vy;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(chmc_pkg::OP_HDG, 16'd100, -16'sd100);
        send_item(chmc_pkg::OP_CAL, 16'd0, 16'd0);
        send_item(chmc_pkg::OP_HDG, 16'd0, 16'd0);
        send_item(chmc_pkg::OP_CAL, 16'd5, 16'd0);
        send_item(chmc_pkg::OP_HDG, 16'd3, 16'd3);
        // x spans -2..5, y spans -3..0: midpoints truncate to 1 and -1
        send_item(chmc_pkg::OP_CAL, -16'sd2, -16'sd3);
        send_item(chmc_pkg::OP_HDG, 16'd1, -16'sd1);
        send_item(chmc_pkg::OP_HDG, -16'sd2, -16'sd1);
        send_item(chmc_pkg::OP_HDG, 16'sh7FFF, -16'sd2);
        send_item(chmc_pkg::OP_HDG, 16'sh8000, 16'sh8000);
        send_item(chmc_pkg::OP_HDG, 16'sh7FFF, 16'sh7FFF);
        send_item(chmc_pkg::OP_HDG, 16'sh8000, 16'sh7FFF);
        send_item(chmc_pkg::OP_HDG, 16'sh7FFF, 16'sh8000);
        send_item(chmc_pkg::OP_HDG, 16'd1, 16'd5);
        send_item(chmc_pkg::OP_HDG, 16'd1, -16'sd30000);
        send_item(chmc_pkg::OP_HDG, 16'd5, 16'd0);
        send_item(chmc_pkg::OP_HDG, -16'sd2, -16'sd3);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            steady <= (k >= 200 && k < 350);
            if (k == 500) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0) @(posedge clk);
            end
            w = 8 + (k * k) / 21;
            if (w > 32767) w = 32767;
            w2 = 2 * w + 8;
            if (w2 > 32767) w2 = 32767;
            if ($urandom_range(99) < 30) begin
                op = chmc_pkg::OP_CAL;
                if (k > 780 && $urandom_range(3) == 0) begin
                    vx = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                    vy = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                end else begin
                    vx = around(w);
                    vy = around(w);
                end
            end else begin
                op  = chmc_pkg::OP_HDG;
                sel = $urandom_range(9);
                if (sel <= 3) begin
                    vx = around(w2);
                    vy = around(w2);
                end else if (sel <= 6) begin
                    {vy, vx} = $urandom;
                end else if (sel == 7) begin
                    vx = rail_sample();
                    vy = rail_sample();
                end else begin
                    vx = around(w2);
                    vy = 16'($urandom_range(65535));
                end
            end
            send_item(op, vx, vy);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
src/chmc_pkg.sv
src/chmc_fifo.sv
src/chmc_front.sv
src/chmc_back.sv
src/compass_heading_with_minmax_calibration.sv
bench/chmc_heading_checker.sv
bench/tb_compass_heading_with_minmax_calibration.sv
